// ----- design/kplr_pkg.sv -----
// Shared types and constants for the keypad long-press and auto-repeat core.
// Used by the lane, merge, result queue, top level and checker files.
`default_nettype none

package kplr_pkg;

	localparam int DELTA_W = 20;
	localparam int CFG_W = 24;
	localparam int CODE_W = 3;
	localparam int NUM_KEYS = 3;
	localparam int CNT_W = 2;
	localparam int CFG_ADDR_W = 2;

	typedef logic [CODE_W-1:0] key_code_t;

	localparam key_code_t KEY_UP = 3'd0;
	localparam key_code_t KEY_DOWN = 3'd1;
	localparam key_code_t KEY_ENTER = 3'd2;
	localparam key_code_t KEY_RIGHT = 3'd3;
	localparam key_code_t KEY_LEFT = 3'd4;
	localparam key_code_t KEY_ESC = 3'd5;

	typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;

	localparam cfg_addr_t CFG_REPEAT_INTERVAL = 2'd0;
	localparam cfg_addr_t CFG_LONGPRESS_TIME = 2'd1;
	localparam cfg_addr_t CFG_RELEASE_SETTLE = 2'd2;

	localparam logic [CFG_W-1:0] REPEAT_INTERVAL_RST = 24'd100000;
	localparam logic [CFG_W-1:0] LONGPRESS_TIME_RST = 24'd500000;
	localparam logic [CFG_W-1:0] RELEASE_SETTLE_RST = 24'd10000;

	typedef enum logic [2:0] {
		PH_RELEASED = 3'b001,
		PH_PRESSED = 3'b010,
		PH_PENDING = 3'b100
	} phase_t;

	typedef struct packed {
		logic vol_up_level;
		logic [7:0] pmic_status;
		logic [DELTA_W-1:0] elapsed_delta;
	} in_item_t;

	typedef struct packed {
		key_code_t key_code;
		logic last_event;
	} out_item_t;

	typedef struct packed {
		logic [CFG_W-1:0] repeat_interval;
		logic [CFG_W-1:0] longpress_time;
		logic [CFG_W-1:0] release_settle;
	} cfg_t;

	// Role and cross-key levels a lane needs for its decisions.
	typedef struct packed {
		logic is_power;
		key_code_t own_code;
		logic power_held;
		logic up_held;
		logic down_held;
	} lane_ctx_t;

	typedef struct packed {
		logic fire;
		key_code_t code;
	} lane_res_t;

	// All reports of one poll, packed to the low slots.
	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic [NUM_KEYS-1:0][CODE_W-1:0] codes;
	} bundle_t;

endpackage

`default_nettype wire

// ----- design/kplr_lane.sv -----
// One key machine: released, pressed and release-pending, with hold timer.
// Depends on kplr_pkg for the phase, context, config and result types.
`default_nettype none

module kplr_lane #(
	parameter int TIMER_BITS = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               enable,
	input  wire logic               pressed,
	input  wire logic [kplr_pkg::DELTA_W-1:0] delta,
	input  wire kplr_pkg::cfg_t     cfg,
	input  wire kplr_pkg::lane_ctx_t ctx,
	output kplr_pkg::lane_res_t     res
);

	localparam int SUM_W = TIMER_BITS + 1;

	kplr_pkg::phase_t phase_q, phase_d;
	logic [TIMER_BITS-1:0] timer_q, timer_d, timer_add;
	logic [SUM_W-1:0] sum;
	logic repeat_q, repeat_d;
	logic long_q, long_d;

	assign sum = {1'b0, timer_q} + SUM_W'(delta);
	// The hold timer sticks at its all-ones value instead of wrapping.
	assign timer_add = sum[TIMER_BITS] ? '1 : sum[TIMER_BITS-1:0];

	always_comb begin
		phase_d = phase_q;
		timer_d = timer_add;
		repeat_d = repeat_q;
		long_d = long_q;
		res.fire = 1'b0;
		res.code = ctx.own_code;
		case (phase_q)
			kplr_pkg::PH_RELEASED: begin
				if (pressed) begin
					timer_d = '0;
					phase_d = kplr_pkg::PH_PRESSED;
				end
			end
			kplr_pkg::PH_PRESSED: begin
				if (pressed) begin
					if (repeat_q && timer_add >= TIMER_BITS'(cfg.repeat_interval)) begin
						res.fire = 1'b1;
						timer_d = '0;
					end else if (!long_q &&
							timer_add >= TIMER_BITS'(cfg.longpress_time)) begin
						if (ctx.is_power) begin
							res.fire = 1'b1;
							if (ctx.down_held) begin
								res.code = kplr_pkg::KEY_RIGHT;
							end else if (ctx.up_held) begin
								res.code = kplr_pkg::KEY_LEFT;
							end else begin
								res.code = kplr_pkg::KEY_ESC;
							end
						end else if (!ctx.power_held) begin
							res.fire = 1'b1;
							timer_d = '0;
							repeat_d = 1'b1;
						end
						long_d = 1'b1;
					end
				end else begin
					if (!long_q) begin
						res.fire = 1'b1;
						phase_d = kplr_pkg::PH_PENDING;
					end else if (timer_add >= TIMER_BITS'(cfg.release_settle)) begin
						phase_d = kplr_pkg::PH_RELEASED;
						timer_d = '0;
						repeat_d = 1'b0;
						long_d = 1'b0;
					end
				end
			end
			default: begin
				// Release-pending always returns to released, ignoring the level.
				phase_d = kplr_pkg::PH_RELEASED;
				timer_d = '0;
				repeat_d = 1'b0;
				long_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= kplr_pkg::PH_RELEASED;
			timer_q <= '0;
			repeat_q <= 1'b0;
			long_q <= 1'b0;
		end else if (enable) begin
			phase_q <= phase_d;
			timer_q <= timer_d;
			repeat_q <= repeat_d;
			long_q <= long_d;
		end
	end

endmodule

`default_nettype wire

// ----- design/kplr_merge.sv -----
// Merges the per-key reports of one poll into a packed bundle, in key order.
// Depends on kplr_pkg for the lane result and bundle types.
`default_nettype none

module kplr_merge (
	input  wire kplr_pkg::lane_res_t res_up,
	input  wire kplr_pkg::lane_res_t res_down,
	input  wire kplr_pkg::lane_res_t res_power,
	output kplr_pkg::bundle_t        bundle
);

	always_comb begin
		bundle.count = kplr_pkg::CNT_W'(res_up.fire) + kplr_pkg::CNT_W'(res_down.fire)
			+ kplr_pkg::CNT_W'(res_power.fire);
		// Slot 0 takes the first key that fired, slot 1 the next one.
		if (res_up.fire) begin
			bundle.codes[0] = res_up.code;
			bundle.codes[1] = res_down.fire ? res_down.code : res_power.code;
		end else begin
			bundle.codes[0] = res_down.fire ? res_down.code : res_power.code;
			bundle.codes[1] = res_power.code;
		end
		bundle.codes[2] = res_power.code;
	end

endmodule

`default_nettype wire

// ----- design/kplr_outq.sv -----
// Two-entry bundle queue that hands out one report per output transfer.
// Depends on kplr_pkg for the bundle and output item types.
`default_nettype none

module kplr_outq (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire kplr_pkg::bundle_t   push_bundle,
	output logic                     full,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output kplr_pkg::out_item_t      out_data
);

	kplr_pkg::bundle_t bq_mem_q [2];
	logic wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic [kplr_pkg::CNT_W-1:0] slot_q;
	kplr_pkg::bundle_t head;
	logic is_last, out_xfer, pop;

	assign head = bq_mem_q[rd_ptr_q];
	assign full = (cnt_q == 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign is_last = (slot_q == head.count - kplr_pkg::CNT_W'(1));
	assign out_data.key_code = head.codes[slot_q];
	assign out_data.last_event = is_last;
	assign out_xfer = out_valid && !out_stall;
	assign pop = out_xfer && is_last;

	always_ff @(posedge clk) begin
		if (push) begin
			bq_mem_q[wr_ptr_q] <= push_bundle;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
			slot_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
				slot_q <= '0;
			end else if (out_xfer) begin
				slot_q <= slot_q + kplr_pkg::CNT_W'(1);
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

`default_nettype wire

// ----- design/keypad_longpress_repeat_fsm_core.sv -----
// Keypad core: three key lanes per poll, merged into a bundle of 0 to 3 reports.
// A poll is taken every cycle while the two-bundle result queue has room; its
// reports are written into the queue on the transfer, and each report takes
// one output transfer, so a poll with n reports takes n output transfers.
// Reset clears all key state and loads the register defaults; no clearing pass.
`default_nettype none

module keypad_longpress_repeat_fsm_core #(
	parameter int TIMER_BITS = 32
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [kplr_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  wire logic [kplr_pkg::CFG_W-1:0]     cfg_wdata,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire kplr_pkg::in_item_t             in_data,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output kplr_pkg::out_item_t                 out_data
);

	kplr_pkg::cfg_t cfg_q;
	logic power_held_q;
	logic in_xfer;
	logic up_lvl, down_lvl, power_lvl;
	kplr_pkg::lane_ctx_t ctx_up, ctx_down, ctx_power;
	kplr_pkg::lane_res_t res_up, res_down, res_power;
	kplr_pkg::bundle_t bundle;
	logic q_full;

	assign in_xfer = in_valid && !in_stall;
	assign in_stall = q_full;
	assign up_lvl = !in_data.vol_up_level;
	assign down_lvl = in_data.pmic_status[1];
	assign power_lvl = in_data.pmic_status[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.repeat_interval <= kplr_pkg::REPEAT_INTERVAL_RST;
			cfg_q.longpress_time <= kplr_pkg::LONGPRESS_TIME_RST;
			cfg_q.release_settle <= kplr_pkg::RELEASE_SETTLE_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				kplr_pkg::CFG_REPEAT_INTERVAL: cfg_q.repeat_interval <= cfg_wdata;
				kplr_pkg::CFG_LONGPRESS_TIME: cfg_q.longpress_time <= cfg_wdata;
				kplr_pkg::CFG_RELEASE_SETTLE: cfg_q.release_settle <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Up and down see last poll's power level, registered here; power sees the current one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			power_held_q <= 1'b0;
		end else if (in_xfer) begin
			power_held_q <= power_lvl;
		end
	end

	always_comb begin
		ctx_up = '{is_power: 1'b0, own_code: kplr_pkg::KEY_UP, power_held: power_held_q,
			up_held: up_lvl, down_held: down_lvl};
		ctx_down = '{is_power: 1'b0, own_code: kplr_pkg::KEY_DOWN,
			power_held: power_held_q, up_held: up_lvl, down_held: down_lvl};
		ctx_power = '{is_power: 1'b1, own_code: kplr_pkg::KEY_ENTER,
			power_held: power_lvl, up_held: up_lvl, down_held: down_lvl};
	end

	kplr_lane #(.TIMER_BITS(TIMER_BITS)) u_lane_up (
		.clk(clk), .arst_n(arst_n), .enable(in_xfer), .pressed(up_lvl),
		.delta(in_data.elapsed_delta), .cfg(cfg_q), .ctx(ctx_up), .res(res_up)
	);

	kplr_lane #(.TIMER_BITS(TIMER_BITS)) u_lane_down (
		.clk(clk), .arst_n(arst_n), .enable(in_xfer), .pressed(down_lvl),
		.delta(in_data.elapsed_delta), .cfg(cfg_q), .ctx(ctx_down), .res(res_down)
	);

	kplr_lane #(.TIMER_BITS(TIMER_BITS)) u_lane_power (
		.clk(clk), .arst_n(arst_n), .enable(in_xfer), .pressed(power_lvl),
		.delta(in_data.elapsed_delta), .cfg(cfg_q), .ctx(ctx_power), .res(res_power)
	);

	kplr_merge u_merge (
		.res_up(res_up), .res_down(res_down), .res_power(res_power), .bundle(bundle)
	);

	kplr_outq u_outq (
		.clk(clk),
		.arst_n(arst_n),
		.push(in_xfer && (bundle.count != '0)),
		.push_bundle(bundle),
		.full(q_full),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

endmodule

`default_nettype wire

// ----- design/kplr_checker.sv -----
// Port-level checks for the keypad core, attached to the top level by bind.
// Depends on kplr_pkg for the payload types and key codes.
`default_nettype none

module kplr_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                in_stall,
	input wire logic                out_valid,
	input wire logic                out_stall,
	input wire kplr_pkg::out_item_t out_data
);

	// A stalled report stays offered and unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled report changed or vanished");

	// The input only stalls while reports are waiting.
	a_stall_needs_data: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no reports pending");

	// A report that is not the last of its poll is followed by another.
	a_bundle_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !out_data.last_event |=> out_valid)
		else $error("poll reports cut short");

	// Finishing a poll's reports always frees room for a new poll.
	a_room_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && out_data.last_event |=> !in_stall)
		else $error("no room after last report transfer");

	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.key_code <= kplr_pkg::KEY_ESC)
		else $error("key code out of range");

endmodule

bind keypad_longpress_repeat_fsm_core kplr_checker u_kplr_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_stall(in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_data(out_data)
);

`default_nettype wire
